/* rtl/core/stack_with_min_max_query_defines.svh */
// Assertion macros for the stack block checker.
`ifndef STACK_WITH_MIN_MAX_QUERY_DEFINES_SVH
`define STACK_WITH_MIN_MAX_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SWMMQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SWMMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/swmmq_pkg.sv */
// Shared types and codes of the stack block.
`default_nettype none

package swmmq_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK = 3'd2;
	localparam logic [FUNC_W-1:0] FN_LIST = 3'd3;
	localparam logic [FUNC_W-1:0] FN_MAX  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_MIN  = 3'd5;

	localparam logic [STATUS_W-1:0] SC_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] SC_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] SC_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_PUT
	} swmmq_state_t;

endpackage

`default_nettype wire

/* rtl/core/stack_with_min_max_query.sv */
// Top level of the LIFO stack with list, maximum and minimum queries.
//
// Input channel (in_valid/in_stall) carries one word: func and value.
// Output channel (out_valid/out_stall) carries words of status, result_value, last.
// Every func from push to min gives one or more output words; last marks the
// final one. Codes 6 and 7 are taken and give no output.
// Steps per input word, set by the registered read port of the stack memory
// and the sequencer scanning it one entry per cycle:
//   push, or any query on an empty stack: idle, put
//   pop, peek: idle, fetch, put
//   list: idle, then fetch and put for each entry
//   max, min: idle, scan of each entry, put
// Each output word is loaded into the output register in the put state.
// While the output is stalled the sequencer holds its pending word; it
// takes at most one more input word and then stalls its input. Reset
// clears the state, the entry count and the output valid flag; stored
// entries and the output data are not cleared.
`default_nettype none

module stack_with_min_max_query #(
	parameter int unsigned STACK_DEPTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [swmmq_pkg::FUNC_W-1:0]         func,
	input  wire logic signed [swmmq_pkg::DATA_W-1:0]  value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [swmmq_pkg::STATUS_W-1:0]            status,
	output logic signed [swmmq_pkg::DATA_W-1:0]       result_value,
	output logic                                      last
);
	import swmmq_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_data;

	swmmq_ctrl #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_func    (func),
		.in_value   (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_status (status),
		.out_value  (result_value),
		.out_last   (last),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	swmmq_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

/* rtl/core/swmmq_mem.sv */
// Stack storage: one write port, one read port with registered read data.
`default_nettype none

module swmmq_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  wire logic                               clk,
	input  wire logic                               wr_en,
	input  wire logic [AW-1:0]                      wr_addr,
	input  wire logic signed [swmmq_pkg::DATA_W-1:0] wr_data,
	input  wire logic [AW-1:0]                      rd_addr,
	output logic signed [swmmq_pkg::DATA_W-1:0]     rd_data
);
	import swmmq_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/core/swmmq_ctrl.sv */
// Stack sequencer: entry count, scan and list walks, output register.
`default_nettype none

module swmmq_ctrl #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5,
	parameter int unsigned CW    = 6
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [swmmq_pkg::FUNC_W-1:0]         in_func,
	input  wire logic signed [swmmq_pkg::DATA_W-1:0]  in_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [swmmq_pkg::STATUS_W-1:0]            out_status,
	output logic signed [swmmq_pkg::DATA_W-1:0]       out_value,
	output logic                                      out_last,
	output logic                                      wr_en,
	output logic [AW-1:0]                             wr_addr,
	output logic signed [swmmq_pkg::DATA_W-1:0]       wr_data,
	output logic [AW-1:0]                             rd_addr,
	input  wire logic signed [swmmq_pkg::DATA_W-1:0]  rd_data
);
	import swmmq_pkg::*;

	swmmq_state_t state_q, state_nx;

	logic [CW-1:0]            count_q;
	logic [AW-1:0]            idx_q;
	logic [FUNC_W-1:0]        op_q;
	logic                     first_q;
	logic signed [DATA_W-1:0] best_q;
	logic [STATUS_W-1:0]      pend_status_q;
	logic signed [DATA_W-1:0] pend_value_q;
	logic                     pend_last_q;
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     out_last_q;

	logic                     accept;
	logic                     is_empty;
	logic                     is_full;
	logic [CW-1:0]            cnt_dec;
	logic [AW-1:0]            top_idx;
	logic [AW-1:0]            idx_dec;
	logic                     idx_zero;
	logic                     out_free;
	logic                     out_load;
	logic                     better;
	logic signed [DATA_W-1:0] best_nx;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign cnt_dec  = count_q - CW'(1);
	assign top_idx  = cnt_dec[AW-1:0];
	assign idx_dec  = idx_q - AW'(1);
	assign idx_zero = (idx_q == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign better   = (op_q == FN_MAX) ? (rd_data > best_q) : (rd_data < best_q);
	assign best_nx  = (first_q || better) ? rd_data : best_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_func) inside
						FN_PUSH:                  state_nx = S_PUT;
						FN_POP, FN_PEEK, FN_LIST: state_nx = is_empty ? S_PUT : S_FETCH;
						FN_MAX, FN_MIN:           state_nx = is_empty ? S_PUT : S_SCAN;
						default:                  state_nx = S_IDLE;
					endcase
				end
			end
			S_FETCH: state_nx = S_PUT;
			S_SCAN: begin
				if (idx_zero) begin
					state_nx = S_PUT;
				end
			end
			S_PUT: begin
				if (out_free) begin
					state_nx = pend_last_q ? S_IDLE : S_FETCH;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		wr_en    = 1'b0;
		rd_addr  = idx_q;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				wr_en    = accept && (in_func == FN_PUSH) && !is_full;
				rd_addr  = top_idx;
			end
			S_FETCH: rd_addr = idx_q;
			S_SCAN:  rd_addr = idx_dec;
			S_PUT: begin
				rd_addr  = idx_dec;
				out_load = out_free;
			end
			default: rd_addr = idx_q;
		endcase
	end

	assign wr_addr = count_q[AW-1:0];
	assign wr_data = in_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept && (in_func == FN_PUSH) && !is_full) begin
				count_q <= count_q + CW'(1);
			end else if (accept && (in_func == FN_POP) && !is_empty) begin
				count_q <= cnt_dec;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= in_func;
				idx_q        <= top_idx;
				first_q      <= 1'b1;
				pend_value_q <= '0;
				pend_last_q  <= 1'b1;
				if (in_func == FN_PUSH) begin
					pend_status_q <= is_full ? SC_FULL : SC_OK;
				end else begin
					pend_status_q <= SC_EMPTY;
				end
			end
			S_FETCH: begin
				pend_status_q <= SC_OK;
				pend_value_q  <= rd_data;
				pend_last_q   <= (op_q != FN_LIST) || idx_zero;
			end
			S_SCAN: begin
				best_q  <= best_nx;
				first_q <= 1'b0;
				idx_q   <= idx_dec;
				if (idx_zero) begin
					pend_status_q <= SC_OK;
					pend_value_q  <= best_nx;
					pend_last_q   <= 1'b1;
				end
			end
			S_PUT: begin
				if (out_free && !pend_last_q) begin
					idx_q <= idx_dec;
				end
			end
			default: begin
				first_q <= 1'b1;
			end
		endcase
		if (out_load) begin
			out_status_q <= pend_status_q;
			out_value_q  <= pend_value_q;
			out_last_q   <= pend_last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/swmmq_checker.sv */
// Port-level assertions for the stack block and their binding.
`default_nettype none

`include "stack_with_min_max_query_defines.svh"

module swmmq_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic [swmmq_pkg::FUNC_W-1:0]         func,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic [swmmq_pkg::STATUS_W-1:0]       status,
	input wire logic signed [swmmq_pkg::DATA_W-1:0]  result_value,
	input wire logic                                 last
);
	import swmmq_pkg::*;

	`SWMMQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(result_value) && $stable(last), "stalled output word changed")

	`SWMMQ_ASSERT_NOW(a_err_single, out_valid && (status != SC_OK), last && (result_value == '0), "error status without last or with nonzero value")

	`SWMMQ_ASSERT_NOW(a_list_blocks, out_valid && !last, in_stall, "input taken while a list walk is in progress")

	`SWMMQ_ASSERT_NEXT(a_take_stalls, in_valid && !in_stall && (func == FN_PUSH), in_stall, "input not stalled after a push was taken")

endmodule

bind stack_with_min_max_query swmmq_checker u_swmmq_checker (.*);

`default_nettype wire
